[src/qrm_pkg.sv]
// Shared constants and helpers for the quaternion to rotation matrix block.
package qrm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int LANES     = 9;
  localparam int QW        = FRAC_BITS + 1;           // quotient bits, q <= 2^FRAC_BITS
  localparam int PW        = 32;                      // product width
  localparam int NW        = 33;                      // squared norm width
  localparam int NUMW      = 35;                      // signed numerator width
  localparam int MW        = 33;                      // numerator magnitude width
  localparam int DW        = NW + 1;                  // divisor 2n
  localparam int RW        = DW + QW;                 // partial remainder width
  localparam int SW        = (QW + 2 > 17) ? QW + 2 : 17;
  localparam logic signed [15:0] ONE =
      (FRAC_BITS >= 15) ? 16'sh7fff : 16'(64'd1 << FRAC_BITS);

  function automatic logic signed [15:0] sat16(input logic neg, input logic [QW-1:0] q);
    logic signed [SW-1:0] v;
    logic signed [15:0]   r;
    v = signed'(SW'(q));
    if (neg) begin
      v = -v;
    end
    if (v > signed'(SW'(32767))) begin
      r = 16'sh7fff;
    end else if (v < -signed'(SW'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[src/qrm_if.sv]
// Valid/ready channel interfaces for quaternion input and matrix output.
interface qrm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] q_x;
  logic signed [15:0] q_y;
  logic signed [15:0] q_z;
  logic signed [15:0] q_w;
  modport source (output valid, q_x, q_y, q_z, q_w, input ready);
  modport sink   (input valid, q_x, q_y, q_z, q_w, output ready);
endinterface

interface qrm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;
  logic               zero_norm;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                  output ready);
endinterface

[src/quaternion_to_rotation_matrix.sv]
// Pipelined quaternion to 3x3 rotation matrix with folded normalization.
//
//  channel | dir | payload
//  quat    | in  | q_x, q_y, q_z, q_w (signed Q2.14)
//  mat     | out | m00..m22 (signed Q2.14, saturated), zero_norm
//
// One transfer per cycle while the output is not stalled. Stages in order: products,
// sums, magnitude and rounding bias, one restoring-division stage per quotient bit for
// all nine entries in parallel, then sign and saturation into the output register.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Synchronous reset clears all valid bits.
module quaternion_to_rotation_matrix (
  input logic       clk,
  input logic       rst,
  qrm_in_if.sink    quat,
  qrm_out_if.source mat
);

  localparam int QW   = qrm_pkg::QW;
  localparam int NL   = qrm_pkg::LANES;
  localparam int RW   = qrm_pkg::RW;
  localparam int DW   = qrm_pkg::DW;

  logic en;

  // stage 1: products
  logic                      v1;
  logic                      z1;
  logic signed [qrm_pkg::PW-1:0] xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;

  // stage 2: norm and numerators
  logic                        v2;
  logic                        z2;
  logic [qrm_pkg::NW-1:0]      n2;
  logic signed [qrm_pkg::NUMW-1:0] num2 [NL];

  // stage 3: magnitude and dividend
  logic                   v3;
  logic                   z3;
  logic [DW-1:0]          d3;
  logic [RW-1:0]          rem3 [NL];
  logic                   neg3 [NL];

  // division stages
  logic          dv   [QW];
  logic          dz   [QW];
  logic [DW-1:0] dd   [QW];
  logic [RW-1:0] remd [QW][NL];
  logic [QW-1:0] qd   [QW][NL];
  logic          negd [QW][NL];

  // output register
  logic               vo;
  logic               zo;
  logic signed [15:0] mo [NL];

  assign en         = !(vo && !mat.ready);
  assign quat.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= quat.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1 <= (quat.q_x == 16'sd0) && (quat.q_y == 16'sd0) &&
            (quat.q_z == 16'sd0) && (quat.q_w == 16'sd0);
      xx <= quat.q_x * quat.q_x;
      yy <= quat.q_y * quat.q_y;
      zz <= quat.q_z * quat.q_z;
      ww <= quat.q_w * quat.q_w;
      xy <= quat.q_x * quat.q_y;
      xz <= quat.q_x * quat.q_z;
      yz <= quat.q_y * quat.q_z;
      xw <= quat.q_x * quat.q_w;
      yw <= quat.q_y * quat.q_w;
      zw <= quat.q_z * quat.q_w;
    end
  end

  logic signed [qrm_pkg::NUMW-1:0] exx, eyy, ezz, eww, exy, exz, eyz, exw, eyw, ezw;
  assign exx = qrm_pkg::NUMW'(xx);
  assign eyy = qrm_pkg::NUMW'(yy);
  assign ezz = qrm_pkg::NUMW'(zz);
  assign eww = qrm_pkg::NUMW'(ww);
  assign exy = qrm_pkg::NUMW'(xy);
  assign exz = qrm_pkg::NUMW'(xz);
  assign eyz = qrm_pkg::NUMW'(yz);
  assign exw = qrm_pkg::NUMW'(xw);
  assign eyw = qrm_pkg::NUMW'(yw);
  assign ezw = qrm_pkg::NUMW'(zw);

  always_ff @(posedge clk) begin
    if (en) begin
      z2      <= z1;
      n2      <= qrm_pkg::NW'(xx) + qrm_pkg::NW'(yy) + qrm_pkg::NW'(zz) + qrm_pkg::NW'(ww);
      num2[0] <= eww + exx - eyy - ezz;
      num2[1] <= (exy - ezw) <<< 1;
      num2[2] <= (exz + eyw) <<< 1;
      num2[3] <= (exy + ezw) <<< 1;
      num2[4] <= eww - exx + eyy - ezz;
      num2[5] <= (eyz - exw) <<< 1;
      num2[6] <= (exz - eyw) <<< 1;
      num2[7] <= (eyz + exw) <<< 1;
      num2[8] <= eww - exx - eyy + ezz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z3 <= z2;
      d3 <= {n2, 1'b0};
      for (int l = 0; l < NL; l++) begin
        logic [qrm_pkg::MW-1:0] mag;
        mag     = num2[l][qrm_pkg::NUMW-1] ? qrm_pkg::MW'(-num2[l]) : qrm_pkg::MW'(num2[l]);
        neg3[l] <= num2[l][qrm_pkg::NUMW-1];
        rem3[l] <= {RW'(mag) << QW} + RW'(n2);
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    logic          vin;
    logic          zin;
    logic [DW-1:0] din;
    logic [RW-1:0] rin  [NL];
    logic [QW-1:0] qin  [NL];
    logic          nin  [NL];

    if (k == 0) begin : g_first
      assign vin = v3;
      assign zin = z3;
      assign din = d3;
      for (genvar l = 0; l < NL; l++) begin : g_l
        assign rin[l] = rem3[l];
        assign qin[l] = '0;
        assign nin[l] = neg3[l];
      end
    end else begin : g_next
      assign vin = dv[k-1];
      assign zin = dz[k-1];
      assign din = dd[k-1];
      for (genvar l = 0; l < NL; l++) begin : g_l
        assign rin[l] = remd[k-1][l];
        assign qin[l] = qd[k-1][l];
        assign nin[l] = negd[k-1][l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dz[k] <= zin;
        dd[k] <= din;
        for (int l = 0; l < NL; l++) begin
          logic [RW:0] diff;
          diff       = {1'b0, rin[l]} - {1'b0, RW'(din) << SH};
          remd[k][l] <= diff[RW] ? rin[l] : diff[RW-1:0];
          qd[k][l]   <= {qin[l][QW-2:0], !diff[RW]};
          negd[k][l] <= nin[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= dv[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zo <= dz[QW-1];
      for (int l = 0; l < NL; l++) begin
        if (dz[QW-1]) begin
          mo[l] <= (l == 0 || l == 4 || l == 8) ? qrm_pkg::ONE : 16'sd0;
        end else begin
          mo[l] <= qrm_pkg::sat16(negd[QW-1][l], qd[QW-1][l]);
        end
      end
    end
  end

  assign mat.valid     = vo;
  assign mat.zero_norm = zo;
  assign mat.m00       = mo[0];
  assign mat.m01       = mo[1];
  assign mat.m02       = mo[2];
  assign mat.m10       = mo[3];
  assign mat.m11       = mo[4];
  assign mat.m12       = mo[5];
  assign mat.m20       = mo[6];
  assign mat.m21       = mo[7];
  assign mat.m22       = mo[8];

  a_rst_clears: assert property (@(posedge clk) rst |=> !vo && !v1)
    else $error("valid bits not cleared by reset");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v3 && en) |=> dv[0])
    else $error("item lost entering the divider");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (dv[QW-1] && !dz[QW-1]) |->
      (qd[QW-1][0] <= QW'(64'd1 << qrm_pkg::FRAC_BITS)) &&
      (qd[QW-1][4] <= QW'(64'd1 << qrm_pkg::FRAC_BITS)))
    else $error("quotient above one");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    (vo && zo) |-> (mo[0] == qrm_pkg::ONE) && (mo[1] == 16'sd0) && (mo[8] == qrm_pkg::ONE))
    else $error("zero quaternion did not give identity");

endmodule
